### rtl/fpdiv_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point divider package
// Shared types and constants of the fixed-point divider.
// ----------------------------------------------------------------------------
package fpdiv_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MAG_W  = 31;
    localparam int unsigned FRAC_W = 5;
    localparam int unsigned SHFT_W = 5;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned ADDR_W = 2;

    localparam logic [MAG_W-1:0]  MAG_MAX    = {MAG_W{1'b1}};
    localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIV0  = 2'd3
    } t_status;

    typedef enum logic [ADDR_W-1:0] {
        REG_FRAC_BITS = 2'd0
    } t_reg_addr;

endpackage

### rtl/fpdiv_if.sv
// ----------------------------------------------------------------------------
// Fixed-point divider channels
// Valid/ready channels for operand words and result words.
// ----------------------------------------------------------------------------
interface fpdiv_in_if import fpdiv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] dividend;
    logic signed [DATA_W-1:0] divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);
endinterface

interface fpdiv_out_if import fpdiv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] quotient;
    t_status                  status;

    modport source (output valid, output quotient, output status, input ready);
    modport sink (input valid, input quotient, input status, output ready);
endinterface

### rtl/fpdiv_regs.sv
// ----------------------------------------------------------------------------
// Fixed-point divider registers
// APB-style register file holding the fractional bit count.
// ----------------------------------------------------------------------------
module fpdiv_regs import fpdiv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [FRAC_W-1:0] o_frac_bits
);

    logic [FRAC_W-1:0] r_frac_bits;
    logic              wr_frac;

    assign wr_frac = psel && penable && pwrite && (paddr == REG_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= FRAC_RESET;
        end else if (wr_frac) begin
            r_frac_bits <= pwdata[FRAC_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_FRAC_BITS) begin
            prdata = {{(DATA_W-FRAC_W){1'b0}}, r_frac_bits};
        end
    end

    assign pready      = 1'b1;
    assign o_frac_bits = r_frac_bits;

endmodule

### rtl/fpdiv_lzc.sv
// ----------------------------------------------------------------------------
// Fixed-point divider leading-zero counter
// Counts leading zeros of a nonzero magnitude word.
// ----------------------------------------------------------------------------
module fpdiv_lzc import fpdiv_pkg::*; (
    input  logic [MAG_W-1:0]  i_value,
    output logic [SHFT_W-1:0] o_count
);

    always_comb begin
        o_count = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (i_value[i]) begin
                o_count = SHFT_W'(MAG_W - 1 - i);
            end
        end
    end

endmodule

### rtl/fpdiv_step.sv
// ----------------------------------------------------------------------------
// Fixed-point divider step unit
// One restoring compare-subtract step producing one quotient bit.
// ----------------------------------------------------------------------------
module fpdiv_step import fpdiv_pkg::*; (
    input  logic [DATA_W-1:0] i_rem,
    input  logic [MAG_W-1:0]  i_den,
    input  logic [DATA_W-1:0] i_q,
    output logic [DATA_W-1:0] o_rem,
    output logic [DATA_W-1:0] o_q
);

    logic [DATA_W-1:0] den_ext;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] kept;
    logic              ge;

    assign den_ext = {1'b0, i_den};
    assign ge      = (i_rem >= den_ext);
    assign diff    = i_rem - den_ext;
    assign kept    = ge ? diff : i_rem;
    assign o_rem   = {kept[DATA_W-2:0], 1'b0};
    assign o_q     = {i_q[DATA_W-2:0], ge};

endmodule

### rtl/fixed_point_divide_core.sv
// ----------------------------------------------------------------------------
// Fixed-point divide core
// An accepted word passes MAG, LZC, NORM, DIV and FIN; DIV uses the single
// restoring step unit, and n = frac_bits - lz(|dividend|) + lz(|divisor|) in 0..31
// sets its number of steps; special cases skip DIV and go straight to FIN.
// One division at a time: a new word is accepted only in the idle state.
// Synchronous active-low reset returns to idle and sets frac_bits to 16.
// ----------------------------------------------------------------------------
module fixed_point_divide_core import fpdiv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fpdiv_in_if.sink          i_in,
    fpdiv_out_if.source       o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MAG  = 6'b000010,
        S_LZC  = 6'b000100,
        S_NORM = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_a, n_a, r_b, n_b;
    logic [MAG_W-1:0]  r_ma, n_ma, r_mb, n_mb;
    logic [SHFT_W-1:0] r_sa, n_sa, r_sb, n_sb;
    logic [DATA_W-1:0] r_rem, n_rem, r_q, n_q;
    logic [MAG_W-1:0]  r_den, n_den;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    t_status           r_st, n_st;
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_oq, n_oq;
    t_status           r_ost, n_ost;

    logic [FRAC_W-1:0] frac_bits;
    logic [SHFT_W-1:0] lz_a, lz_b;
    logic [DATA_W-1:0] step_rem, step_q;
    logic [CNT_W:0]    bits;
    logic [MAG_W-1:0]  fin_mag;
    logic              out_free;

    function automatic logic [MAG_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] m;
        m = v[DATA_W-1] ? (DATA_W'(0) - v) : v;
        return m[DATA_W-1] ? MAG_MAX : m[MAG_W-1:0];
    endfunction

    fpdiv_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_frac_bits (frac_bits)
    );

    fpdiv_lzc u_lzc_a (
        .i_value (r_ma),
        .o_count (lz_a)
    );

    fpdiv_lzc u_lzc_b (
        .i_value (r_mb),
        .o_count (lz_b)
    );

    fpdiv_step u_step (
        .i_rem (r_rem),
        .i_den (r_den),
        .i_q   (r_q),
        .o_rem (step_rem),
        .o_q   (step_q)
    );

    assign bits = {2'b00, frac_bits} - {2'b00, r_sa} + {2'b00, r_sb};
    assign fin_mag = r_q[DATA_W-1] ? MAG_MAX : r_q[MAG_W-1:0];
    assign out_free = !r_ovalid || o_out.ready;

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ovalid;
    assign o_out.quotient = r_oq;
    assign o_out.status   = r_ost;

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_rem    = r_rem;
        n_den    = r_den;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_st     = r_st;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oq     = r_oq;
        n_ost    = r_ost;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_a     = i_in.dividend;
                    n_b     = i_in.divisor;
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                n_neg = r_a[DATA_W-1] ^ r_b[DATA_W-1];
                n_ma  = magnitude(r_a);
                n_mb  = magnitude(r_b);
                n_q   = '0;
                n_st  = ST_OK;
                if (r_b == '0) begin
                    n_st    = ST_DIV0;
                    n_state = S_FIN;
                end else if (r_a == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_LZC;
                end
            end
            S_LZC: begin
                n_sa    = lz_a;
                n_sb    = lz_b;
                n_state = S_NORM;
            end
            S_NORM: begin
                n_rem = {1'b0, r_ma << r_sa};
                n_den = r_mb << r_sb;
                n_cnt = bits[CNT_W-1:0] + CNT_W'(1);
                if (bits[CNT_W]) begin
                    n_st    = ST_UNDER;
                    n_state = S_FIN;
                end else if (bits[CNT_W-1]) begin
                    n_q     = {1'b0, MAG_MAX};
                    n_st    = ST_OVER;
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = step_rem;
                n_q   = step_q;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oq     = r_neg ? (DATA_W'(0) - {1'b0, fin_mag}) : {1'b0, fin_mag};
                    n_ost    = r_q[DATA_W-1] ? ST_OVER : r_st;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_sa  <= n_sa;
        r_sb  <= n_sb;
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_st  <= n_st;
        r_oq  <= n_oq;
        r_ost <= n_ost;
    end

endmodule
